// ===== hw/rtl/prp_list_walker_defines.svh =====
// Assertion macros for the PRP list walker.
`ifndef PRP_LIST_WALKER_DEFINES_SVH
`define PRP_LIST_WALKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/prp_pkg.sv =====
// Shared types, codes and helper functions of the PRP list walker.
`timescale 1ns / 1ps

package prp_pkg;

	localparam int CMDQ_DEPTH = 4;
	localparam int ADDR_W     = 6;

	localparam logic [1:0] KIND_SEG   = 2'd0;
	localparam logic [1:0] KIND_FETCH = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INVALID    = 2'd1;
	localparam logic [1:0] ST_UNEXPECTED = 2'd2;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_ENTRY = 1'b1;

	localparam logic [2:0] REG_PAGE_SHIFT   = 3'd0;
	localparam logic [2:0] REG_LIST_ENTRIES = 3'd1;
	localparam logic [2:0] REG_CMB_ENABLE   = 3'd2;
	localparam logic [2:0] REG_CMB_BASE     = 3'd3;
	localparam logic [2:0] REG_CMB_BYTES    = 3'd4;

	localparam logic [4:0]  RST_PAGE_SHIFT   = 5'd12;
	localparam logic [13:0] RST_LIST_ENTRIES = 14'd512;

	typedef struct packed {
		logic        req_type;
		logic [63:0] first_pointer;
		logic [63:0] second_pointer;
		logic [31:0] byte_count;
		logic [63:0] list_entry;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] address;
		logic [31:0] amount;
		logic        in_window;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [4:0]  shift;
		logic [15:0] page_mask;
		logic [13:0] lim;
		logic        cmb_enable;
		logic [63:0] cmb_base;
		logic [31:0] cmb_bytes;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_DONE         = 3'd0,
		OP_SEG          = 3'd1,
		OP_SEG_DONE     = 3'd2,
		OP_SEG_SEG_DONE = 3'd3,
		OP_SEG_FETCH    = 3'd4,
		OP_FETCH        = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  status;
		logic        win;
		logic [63:0] addr_a;
		logic [63:0] addr_b;
		logic [31:0] amt_a;
		logic [31:0] amt_b;
	} cmd_t;

	function automatic logic [4:0] sat_shift(input logic [4:0] s);
		logic [4:0] r;
		r = s;
		if (s < 5'd12) r = 5'd12;
		if (s > 5'd16) r = 5'd16;
		return r;
	endfunction

	function automatic logic [13:0] sat_entries(input logic [13:0] n);
		logic [13:0] r;
		r = n;
		if (n < 14'd2) r = 14'd2;
		if (n > 14'd8192) r = 14'd8192;
		return r;
	endfunction

	function automatic logic [15:0] page_mask(input logic [4:0] s);
		logic [16:0] p;
		p = 17'd1 << s;
		return 16'(p - 17'd1);
	endfunction

endpackage

// ===== hw/rtl/prp_front.sv =====
// Front end: walk state, pointer checks and command classification.
`timescale 1ns / 1ps

module prp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  prp_pkg::cfg_t  cfg,
	input  logic           accept,
	input  prp_pkg::req_t  req,
	output prp_pkg::cmd_t  cmd
);

	logic        walking_q, walking_d;
	logic [31:0] bytes_left_q, bytes_left_d;
	logic [12:0] entry_index_q, entry_index_d;
	logic        window_q, window_d;

	logic [16:0] page;
	logic [31:0] page32;
	logic [16:0] first_full;
	logic [31:0] first;
	logic [31:0] rest;
	logic        rest_le_page;
	logic        p2_mis;
	logic [64:0] diff;
	logic        win;
	logic        e_ok;
	logic        at_end;
	logic [31:0] take;
	logic [31:0] left;

	always_comb begin
		page         = {1'b0, cfg.page_mask} + 17'd1;
		page32       = {15'd0, page};
		first_full   = page - {1'b0, req.first_pointer[15:0] & cfg.page_mask};
		first        = (req.byte_count < {15'd0, first_full}) ?
			req.byte_count : {15'd0, first_full};
		rest         = req.byte_count - first;
		rest_le_page = rest <= page32;
		p2_mis       = |(req.second_pointer[15:0] & cfg.page_mask);
		diff         = {1'b0, req.first_pointer} - {1'b0, cfg.cmb_base};
		win          = cfg.cmb_enable && !diff[64] && (diff[63:32] == 32'd0) &&
			(diff[31:0] < cfg.cmb_bytes);
		e_ok         = (req.list_entry != 64'd0) &&
			!(|(req.list_entry[15:0] & cfg.page_mask));
		at_end       = ({1'b0, entry_index_q} >= (cfg.lim - 14'd1)) &&
			(bytes_left_q > page32);
		take         = (bytes_left_q < page32) ? bytes_left_q : page32;
		left         = bytes_left_q - take;
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = prp_pkg::OP_DONE;
		cmd.status    = prp_pkg::ST_OK;
		walking_d     = walking_q;
		bytes_left_d  = bytes_left_q;
		entry_index_d = entry_index_q;
		window_d      = window_q;
		if (req.req_type == prp_pkg::REQ_START) begin
			walking_d     = 1'b0;
			bytes_left_d  = 32'd0;
			entry_index_d = 13'd0;
			window_d      = 1'b0;
			if (req.first_pointer == 64'd0) begin
				cmd.status = prp_pkg::ST_INVALID;
			end else if ((rest != 32'd0) && ((req.second_pointer == 64'd0) ||
					(rest_le_page && p2_mis))) begin
				window_d   = win;
				cmd.status = prp_pkg::ST_INVALID;
			end else begin
				window_d   = win;
				cmd.win    = win;
				cmd.addr_a = req.first_pointer;
				cmd.amt_a  = first;
				cmd.addr_b = req.second_pointer;
				cmd.amt_b  = rest;
				if (rest == 32'd0) begin
					cmd.op = prp_pkg::OP_SEG_DONE;
				end else if (rest_le_page) begin
					cmd.op = prp_pkg::OP_SEG_SEG_DONE;
				end else begin
					cmd.op       = prp_pkg::OP_SEG_FETCH;
					walking_d    = 1'b1;
					bytes_left_d = rest;
				end
			end
		end else begin
			if (!walking_q) begin
				cmd.status = prp_pkg::ST_UNEXPECTED;
			end else if (!e_ok) begin
				cmd.status    = prp_pkg::ST_INVALID;
				walking_d     = 1'b0;
				bytes_left_d  = 32'd0;
				entry_index_d = 13'd0;
			end else if (at_end) begin
				cmd.op        = prp_pkg::OP_FETCH;
				cmd.addr_a    = req.list_entry;
				cmd.amt_a     = bytes_left_q;
				entry_index_d = 13'd0;
			end else begin
				cmd.win       = window_q;
				cmd.addr_a    = req.list_entry;
				cmd.amt_a     = take;
				bytes_left_d  = left;
				entry_index_d = entry_index_q + 13'd1;
				if (left == 32'd0) begin
					cmd.op        = prp_pkg::OP_SEG_DONE;
					walking_d     = 1'b0;
					entry_index_d = 13'd0;
				end else begin
					cmd.op = prp_pkg::OP_SEG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q     <= 1'b0;
			bytes_left_q  <= 32'd0;
			entry_index_q <= 13'd0;
			window_q      <= 1'b0;
		end else if (accept) begin
			walking_q     <= walking_d;
			bytes_left_q  <= bytes_left_d;
			entry_index_q <= entry_index_d;
			window_q      <= window_d;
		end
	end

endmodule

// ===== hw/rtl/prp_cmdq.sv =====
// Command queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module prp_cmdq #(
	parameter int DEPTH = prp_pkg::CMDQ_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  prp_pkg::cmd_t  wdata,
	output logic           full,
	input  logic           rd,
	output prp_pkg::cmd_t  rdata,
	output logic           valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	prp_pkg::cmd_t   slot_q [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr, do_rd;

	assign full   = count_q == CW'(DEPTH);
	assign valid  = count_q != '0;
	assign do_wr  = wr && !full;
	assign do_rd  = rd && valid;
	assign rdata  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/prp_back.sv =====
// Back end: expands commands into result items and holds the output register.
`timescale 1ns / 1ps

module prp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  prp_pkg::cfg_t  cfg,
	input  logic           cmd_valid,
	input  prp_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output prp_pkg::rsp_t  rsp
);

	logic [1:0]     step_q;
	logic           out_valid_q;
	prp_pkg::rsp_t  rsp_q;
	prp_pkg::rsp_t  rsp_d;

	logic [1:0]  kind;
	logic [63:0] raw;
	logic [31:0] amt;
	logic [1:0]  st;
	logic        lst;
	logic [32:0] sum;
	logic [32:0] nent;
	logic [31:0] fcount;
	logic        load;

	always_comb begin
		kind = prp_pkg::KIND_DONE;
		raw  = 64'd0;
		amt  = 32'd0;
		st   = prp_pkg::ST_OK;
		lst  = 1'b1;
		unique case (cmd.op)
			prp_pkg::OP_DONE: begin
				st = cmd.status;
			end
			prp_pkg::OP_SEG: begin
				kind = prp_pkg::KIND_SEG;
				raw  = cmd.addr_a;
				amt  = cmd.amt_a;
			end
			prp_pkg::OP_SEG_DONE: begin
				if (step_q == 2'd0) begin
					kind = prp_pkg::KIND_SEG;
					raw  = cmd.addr_a;
					amt  = cmd.amt_a;
					lst  = 1'b0;
				end
			end
			prp_pkg::OP_SEG_SEG_DONE: begin
				if (step_q == 2'd0) begin
					kind = prp_pkg::KIND_SEG;
					raw  = cmd.addr_a;
					amt  = cmd.amt_a;
					lst  = 1'b0;
				end else if (step_q == 2'd1) begin
					kind = prp_pkg::KIND_SEG;
					raw  = cmd.addr_b;
					amt  = cmd.amt_b;
					lst  = 1'b0;
				end
			end
			prp_pkg::OP_SEG_FETCH: begin
				if (step_q == 2'd0) begin
					kind = prp_pkg::KIND_SEG;
					raw  = cmd.addr_a;
					amt  = cmd.amt_a;
					lst  = 1'b0;
				end else begin
					kind = prp_pkg::KIND_FETCH;
					raw  = cmd.addr_b;
					amt  = cmd.amt_b;
				end
			end
			prp_pkg::OP_FETCH: begin
				kind = prp_pkg::KIND_FETCH;
				raw  = cmd.addr_a;
				amt  = cmd.amt_a;
			end
			default: begin
				st = cmd.status;
			end
		endcase
	end

	always_comb begin
		sum    = {1'b0, amt} + {17'd0, cfg.page_mask};
		nent   = sum >> cfg.shift;
		fcount = (nent < {19'd0, cfg.lim}) ? nent[31:0] : {18'd0, cfg.lim};

		rsp_d.result_kind = kind;
		rsp_d.address     = ((kind == prp_pkg::KIND_SEG) && cmd.win) ?
			raw - cfg.cmb_base : raw;
		rsp_d.amount      = (kind == prp_pkg::KIND_FETCH) ? fcount : amt;
		rsp_d.in_window   = (kind == prp_pkg::KIND_SEG) && cmd.win;
		rsp_d.status      = st;
		rsp_d.last        = lst;
	end

	assign load    = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = load && lst;
	assign empty   = !out_valid_q;
	assign rsp     = rsp_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= lst ? 2'd0 : step_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/prp_list_walker.sv =====
// An accepted item passes the command queue, then the output register, before a result shows.
// Throughput: one result per cycle from the back end unless a held result is not popped;
// a start command gives one to three results, a list entry one or two.
// The front end takes an item each cycle while the command queue has room.
// Reset: asynchronous, clears walk state, queue and output; registers return to defaults.
`timescale 1ns / 1ps
`include "prp_list_walker_defines.svh"

module prp_list_walker #(
	parameter int CMD_SLOTS = prp_pkg::CMDQ_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [prp_pkg::ADDR_W-1:0]  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  prp_pkg::req_t               req,
	output logic                        empty,
	input  logic                        pop,
	output prp_pkg::rsp_t               rsp
);

	logic [4:0]  page_shift_q;
	logic [13:0] list_entries_q;
	logic        cmb_enable_q;
	logic [63:0] cmb_base_q;
	logic [31:0] cmb_bytes_q;

	prp_pkg::cfg_t  cfg;
	prp_pkg::cmd_t  cmd_in;
	prp_pkg::cmd_t  cmd_head;
	logic           cfg_wr;
	logic [2:0]     reg_idx;
	logic           accept;
	logic           cmd_valid;
	logic           cmd_pop;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[5:3];
	assign accept  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q   <= prp_pkg::RST_PAGE_SHIFT;
			list_entries_q <= prp_pkg::RST_LIST_ENTRIES;
			cmb_enable_q   <= 1'b0;
			cmb_base_q     <= 64'd0;
			cmb_bytes_q    <= 32'd0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				prp_pkg::REG_PAGE_SHIFT:   page_shift_q   <= pwdata[4:0];
				prp_pkg::REG_LIST_ENTRIES: list_entries_q <= pwdata[13:0];
				prp_pkg::REG_CMB_ENABLE:   cmb_enable_q   <= pwdata[0];
				prp_pkg::REG_CMB_BASE:     cmb_base_q     <= pwdata;
				prp_pkg::REG_CMB_BYTES:    cmb_bytes_q    <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			prp_pkg::REG_PAGE_SHIFT:   prdata = {59'd0, page_shift_q};
			prp_pkg::REG_LIST_ENTRIES: prdata = {50'd0, list_entries_q};
			prp_pkg::REG_CMB_ENABLE:   prdata = {63'd0, cmb_enable_q};
			prp_pkg::REG_CMB_BASE:     prdata = cmb_base_q;
			prp_pkg::REG_CMB_BYTES:    prdata = {32'd0, cmb_bytes_q};
			default:                   prdata = 64'd0;
		endcase
	end

	always_comb begin
		cfg.shift      = prp_pkg::sat_shift(page_shift_q);
		cfg.page_mask  = prp_pkg::page_mask(cfg.shift);
		cfg.lim        = prp_pkg::sat_entries(list_entries_q);
		cfg.cmb_enable = cmb_enable_q;
		cfg.cmb_base   = cmb_base_q;
		cfg.cmb_bytes  = cmb_bytes_q;
	end

	prp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.req    (req),
		.cmd    (cmd_in)
	);

	prp_cmdq #(
		.DEPTH (CMD_SLOTS)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (cmd_in),
		.full   (full),
		.rd     (cmd_pop),
		.rdata  (cmd_head),
		.valid  (cmd_valid)
	);

	prp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

	`PRP_ASSERT_NOW(a_done_last, !empty && (rsp.result_kind == prp_pkg::KIND_DONE), rsp.last, "done item without last")
	`PRP_ASSERT_NOW(a_fetch_range, !empty && (rsp.result_kind == prp_pkg::KIND_FETCH), (rsp.amount != 32'd0) && (rsp.amount <= {18'd0, cfg.lim}), "fetch count out of range")
	`PRP_ASSERT_NOW(a_seg_page, !empty && (rsp.result_kind == prp_pkg::KIND_SEG), rsp.amount <= ({16'd0, cfg.page_mask} + 32'd1), "segment longer than a page")
	`PRP_ASSERT_NEXT(a_cmd_drains, cmd_valid && empty, !empty, "queued command not sequenced")

endmodule
